>>> rtl/rspd_pkg.sv
// Package for the RGBW strip pattern dimmer: register map, pattern codes,
// color layouts, the fade step and the duty scaling.
// No dependencies; every other file of the block refers to it by scoped names.
package rspd_pkg;

    localparam int NUM_STRIPS_DEF = 3;
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;

    localparam logic [7:0] FULL_LEVEL  = 8'd255;
    localparam logic [7:0] HALF_LEVEL  = 8'd128;
    localparam logic [7:0] FADE_STEP   = 8'd5;
    localparam logic [7:0] FADE_TOP    = FULL_LEVEL - FADE_STEP;
    localparam logic signed [9:0] SET_FADE_DOWN = -10'sd1;
    localparam logic signed [9:0] SET_FADE_UP   = 10'sd256;
    localparam logic signed [9:0] SET_RESET     = 10'sd255;

    typedef enum logic [2:0] {
        REG_POWER      = 3'd0,
        REG_BRIGHTNESS = 3'd1,
        REG_RED        = 3'd2,
        REG_GREEN      = 3'd3,
        REG_BLUE       = 3'd4,
        REG_WHITE      = 3'd5,
        REG_PATTERN    = 3'd6,
        REG_NONE       = 3'd7
    } reg_index_t;

    typedef enum logic [2:0] {
        PAT_WHITE    = 3'd0,
        PAT_RGB      = 3'd1,
        PAT_GREEN_RED = 3'd2,
        PAT_RED_WHITE = 3'd3,
        PAT_TRICOLOR  = 3'd4,
        PAT_YELLOW_PURPLE = 3'd5,
        PAT_KEEP_A   = 3'd6,
        PAT_KEEP_B   = 3'd7
    } pattern_t;

    typedef struct packed {
        logic [7:0] w;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } color_t;

    typedef struct packed {
        logic       rising;
        logic [7:0] level;
    } fade_t;

    // Color of one strip for a pattern; odd and mod3 describe the strip's place.
    function automatic color_t pattern_color(
        input pattern_t   pat,
        input logic       odd,
        input logic [1:0] mod3,
        input logic [7:0] wl,
        input logic [7:0] rl,
        input logic [7:0] gl,
        input logic [7:0] bl
    );
        color_t c;
        c = '0;
        case (pat)
            PAT_WHITE: c.w = (wl != 8'd0) ? wl : FULL_LEVEL;
            PAT_RGB:
            begin
                c.r = rl;
                c.g = gl;
                c.b = bl;
            end
            PAT_GREEN_RED:
            begin
                if (odd) c.r = FULL_LEVEL;
                else     c.g = FULL_LEVEL;
            end
            PAT_RED_WHITE:
            begin
                if (odd) c.w = FULL_LEVEL;
                else     c.r = FULL_LEVEL;
            end
            PAT_TRICOLOR:
            begin
                if (mod3 == 2'd0)      c.r = FULL_LEVEL;
                else if (mod3 == 2'd1) c.w = FULL_LEVEL;
                else                   c.b = FULL_LEVEL;
            end
            default:
            begin
                if (odd)
                begin
                    c.r = HALF_LEVEL;
                    c.b = HALF_LEVEL;
                end
                else
                begin
                    c.r = FULL_LEVEL;
                    c.g = FULL_LEVEL;
                end
            end
        endcase
        return c;
    endfunction

    // One breathing step; the level bounces and clamps at both ends.
    function automatic fade_t fade_step(input fade_t cur);
        fade_t nxt;
        nxt = cur;
        if (cur.rising)
        begin
            if (cur.level > FADE_TOP)
            begin
                nxt.level  = FULL_LEVEL;
                nxt.rising = 1'b0;
            end
            else
            begin
                nxt.level = cur.level + FADE_STEP;
            end
        end
        else
        begin
            if (cur.level < FADE_STEP)
            begin
                nxt.level  = 8'd0;
                nxt.rising = 1'b1;
            end
            else
            begin
                nxt.level = cur.level - FADE_STEP;
            end
        end
        return nxt;
    endfunction

    // floor(color * level / 255); the shift-and-add form is exact for 16-bit products.
    function automatic logic [7:0] scale_duty(input logic [7:0] color, input logic [7:0] level);
        logic [15:0] prod;
        logic [16:0] sum;
        prod = color * level;
        sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
        return sum[15:8];
    endfunction

endpackage

>>> rtl/rspd_shade.sv
// Channel duty logic for one strip: scales the four color bytes by the level, or gives zero with power off.
// Depends on rspd_pkg for color_t and scale_duty.
module rspd_shade
(
    input  rspd_pkg::color_t color,
    input  logic [7:0]       level,
    input  logic             power,
    output rspd_pkg::color_t duty
);

    always_comb
    begin
        duty = '0;
        if (power)
        begin
            duty.w = rspd_pkg::scale_duty(color.w, level);
            duty.r = rspd_pkg::scale_duty(color.r, level);
            duty.g = rspd_pkg::scale_duty(color.g, level);
            duty.b = rspd_pkg::scale_duty(color.b, level);
        end
    end

endmodule

>>> rtl/rgbw_strip_pattern_dimmer_top.sv
// Each accepted item is one tick: it may take a breathing step, refreshes the
// strip colors from the selected pattern unless its code keeps them, and
// yields NUM_STRIPS results, one per strip in order, the last one flagged by
// last_strip. Results leave at one per cycle through an output register while
// out_stall is low; one more tick is held in the input register meanwhile.
// Configuration is read and written through the APB port.
// Depends on rspd_pkg and rspd_shade.
module rgbw_strip_pattern_dimmer_top
#(
    parameter int NUM_STRIPS = rspd_pkg::NUM_STRIPS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rspd_pkg::ADDR_W-1:0]  paddr,
    input  logic [rspd_pkg::DATA_W-1:0]  pwdata,
    output logic [rspd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    // tick input
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         advance,
    // strip results
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   strip_index,
    output logic [7:0]                   white_duty,
    output logic [7:0]                   red_duty,
    output logic [7:0]                   green_duty,
    output logic [7:0]                   blue_duty,
    output logic [7:0]                   level_now,
    output logic [2:0]                   pattern_now,
    output logic                         lamp_on,
    output logic                         last_strip
);

    localparam int CNT_W = (NUM_STRIPS > 1) ? $clog2(NUM_STRIPS) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_STRIPS - 1);

    // configuration registers
    logic                    power_on_reg;
    logic signed [9:0]       brightness_reg;
    logic [7:0]              red_reg;
    logic [7:0]              green_reg;
    logic [7:0]              blue_reg;
    logic [7:0]              white_reg;
    logic [2:0]              pattern_sel_reg;

    // tick state
    rspd_pkg::fade_t         fade_reg;
    rspd_pkg::fade_t         fade_next;
    rspd_pkg::color_t        colors_reg [NUM_STRIPS];
    rspd_pkg::color_t        colors_next [NUM_STRIPS];
    logic [2:0]              applied_reg;

    // input register and emitter
    logic                    pend_valid_reg;
    logic                    pend_adv_reg;
    logic                    busy_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    out_valid_reg;
    logic                    out_load;
    logic                    beat;
    logic                    beat_last;
    logic                    apply_tick;

    rspd_pkg::reg_index_t    cfg_idx;
    logic                    cfg_write;
    logic                    fading;
    logic                    fixed_level;
    logic                    pattern_new;
    rspd_pkg::color_t        cur_color;
    rspd_pkg::color_t        cur_duty;

    assign pready    = 1'b1;
    assign cfg_idx   = rspd_pkg::reg_index_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_idx)
            rspd_pkg::REG_POWER:      prdata = {31'd0, power_on_reg};
            rspd_pkg::REG_BRIGHTNESS: prdata = 32'(brightness_reg);
            rspd_pkg::REG_RED:        prdata = {24'd0, red_reg};
            rspd_pkg::REG_GREEN:      prdata = {24'd0, green_reg};
            rspd_pkg::REG_BLUE:       prdata = {24'd0, blue_reg};
            rspd_pkg::REG_WHITE:      prdata = {24'd0, white_reg};
            rspd_pkg::REG_PATTERN:    prdata = {29'd0, pattern_sel_reg};
            default:                  prdata = '0;
        endcase
    end

    // Handshake control.
    assign in_stall   = pend_valid_reg;
    assign out_load   = !out_valid_reg || !out_stall;
    assign beat       = busy_reg && out_load;
    assign beat_last  = beat && (cnt_reg == LAST_CNT);
    assign apply_tick = pend_valid_reg && (!busy_reg || beat_last);

    // Tick update of level and colors.
    assign fading      = (brightness_reg == rspd_pkg::SET_FADE_DOWN) ||
                         (brightness_reg == rspd_pkg::SET_FADE_UP);
    assign fixed_level = (brightness_reg[9:8] == 2'b00);
    assign pattern_new = (pattern_sel_reg <= 3'(rspd_pkg::PAT_YELLOW_PURPLE));

    always_comb
    begin
        fade_next = fade_reg;
        if (pend_adv_reg && fading)
            fade_next = rspd_pkg::fade_step(fade_reg);
        if (fixed_level)
            fade_next.level = brightness_reg[7:0];
    end

    for (genvar g = 0; g < NUM_STRIPS; g++)
    begin : g_color
        localparam logic       ODD  = ((g % 2) != 0);
        localparam logic [1:0] MOD3 = 2'(g % 3);

        assign colors_next[g] = rspd_pkg::pattern_color(
            rspd_pkg::pattern_t'(pattern_sel_reg), ODD, MOD3,
            white_reg, red_reg, green_reg, blue_reg);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                colors_reg[g] <= '0;
            else if (apply_tick && pattern_new)
                colors_reg[g] <= colors_next[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_on_reg    <= 1'b0;
            brightness_reg  <= rspd_pkg::SET_RESET;
            red_reg         <= '0;
            green_reg       <= '0;
            blue_reg        <= '0;
            white_reg       <= '0;
            pattern_sel_reg <= '0;
            fade_reg        <= '{rising: 1'b0, level: rspd_pkg::FULL_LEVEL};
            applied_reg     <= '0;
        end
        else
        begin
            if (apply_tick)
            begin
                fade_reg <= fade_next;
                if (pattern_new)
                    applied_reg <= pattern_sel_reg;
            end
            if (cfg_write)
            begin
                case (cfg_idx)
                    rspd_pkg::REG_POWER:      power_on_reg <= pwdata[0];
                    rspd_pkg::REG_BRIGHTNESS:
                    begin
                        brightness_reg  <= signed'(pwdata[9:0]);
                        fade_reg.rising <= (signed'(pwdata[9:0]) == rspd_pkg::SET_FADE_UP);
                    end
                    rspd_pkg::REG_RED:        red_reg         <= pwdata[7:0];
                    rspd_pkg::REG_GREEN:      green_reg       <= pwdata[7:0];
                    rspd_pkg::REG_BLUE:       blue_reg        <= pwdata[7:0];
                    rspd_pkg::REG_WHITE:      white_reg       <= pwdata[7:0];
                    rspd_pkg::REG_PATTERN:    pattern_sel_reg <= pwdata[2:0];
                    default:                  ;
                endcase
            end
        end
    end

    // Input register: one tick waits here while the previous one is emitted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (apply_tick)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            pend_adv_reg <= advance;
    end

    // Strip sequencer; it reads the tick state that the last apply left.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (apply_tick)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (beat_last)
        begin
            busy_reg <= 1'b0;
        end
        else if (beat)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign cur_color = colors_reg[cnt_reg];

    rspd_shade u_shade
    (
        .color (cur_color),
        .level (fade_reg.level),
        .power (power_on_reg),
        .duty  (cur_duty)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= beat;
    end

    always_ff @(posedge clk)
    begin
        if (beat)
        begin
            strip_index <= 2'(cnt_reg);
            white_duty  <= cur_duty.w;
            red_duty    <= cur_duty.r;
            green_duty  <= cur_duty.g;
            blue_duty   <= cur_duty.b;
            level_now   <= fade_reg.level;
            pattern_now <= applied_reg;
            lamp_on     <= power_on_reg;
            last_strip  <= (cnt_reg == LAST_CNT);
        end
    end

    assign out_valid = out_valid_reg;

endmodule
